// File: hdl/wire_field_byte_serializer_top_defines.svh
// Assertion macros shared by the wire field byte serializer checkers
`ifndef WIRE_FIELD_BYTE_SERIALIZER_TOP_DEFINES_SVH
`define WIRE_FIELD_BYTE_SERIALIZER_TOP_DEFINES_SVH

// clocked check, off while rst is high; expects clk and rst in scope
`define WFBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold
`define WFBS_NEVER(label, expr, msg) \
  `WFBS_ASSERT(label, !(expr), msg)

`endif

// File: hdl/wfbs_pkg.sv
// Shared types, opcodes and constants for the wire field byte serializer
package wfbs_pkg;

  localparam int unsigned ADDR_WIDTH_DEF = 16;
  localparam logic [16:0] CAP_RESET      = 17'h10000;

  localparam logic [7:0] VAL7      = 8'h7f;
  localparam logic [7:0] CONT      = 8'h80;
  localparam int unsigned SHIFT7   = 7;
  localparam int unsigned SHIFT8   = 8;

  // byte index of the final byte for each encoding
  localparam logic [3:0] VARINT_LAST_STEP = 4'd9;
  localparam logic [3:0] FIX16_LAST       = 4'd1;
  localparam logic [3:0] FIX32_LAST       = 4'd3;
  localparam logic [3:0] FIX64_LAST       = 4'd7;

  // register select (paddr bit 2)
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [3:0] {
    OP_RAW      = 4'd0,
    OP_BOOL     = 4'd1,
    OP_VARINT32 = 4'd2,
    OP_VARINT64 = 4'd3,
    OP_INT32    = 4'd4,
    OP_FIXED16  = 4'd5,
    OP_FIXED32  = 4'd6,
    OP_FIXED64  = 4'd7,
    OP_SKIP     = 4'd8,
    OP_RESTART  = 4'd9
  } op_t;

  typedef struct packed {
    logic load;  // take the input item into the datapath
    logic step;  // produce one result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;  // output register empty or being taken
    logic step_last;  // the next result closes the item
  } dp_stat_t;

  function automatic logic op_known(logic [3:0] c);
    return c <= OP_RESTART;
  endfunction

endpackage

// File: hdl/wfbs_ctrl.sv
// Sequencer: accepts items and paces result production
module wfbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [3:0]         command,
  output logic               in_ready,
  input  wfbs_pkg::dp_stat_t stat,
  output wfbs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state, state_next;
  logic   step;
  logic   accept;

  assign step     = (state == S_EMIT) && stat.slot_free;
  // next item may enter alongside the final result of the current one
  assign in_ready = (state == S_IDLE) || (step && stat.step_last);
  assign accept   = in_valid && in_ready;
  assign cmd.step = step;
  assign cmd.load = accept && wfbs_pkg::op_known(command);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (step && stat.step_last) state_next = cmd.load ? S_EMIT : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/wfbs_dp.sv
// Datapath: operand shifter, write position and the result register
module wfbs_dp #(
  parameter int unsigned ADDR_WIDTH = wfbs_pkg::ADDR_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  wfbs_pkg::dp_cmd_t  cmd,
  output wfbs_pkg::dp_stat_t stat,
  input  logic [3:0]         command,
  input  logic [63:0]        value,
  input  logic [16:0]        capacity,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic [15:0]        byte_address,
  output logic               byte_written,
  output logic               out_of_space,
  output logic [16:0]        space_left,
  output logic               last
);

  localparam bit          ClampOn  = (ADDR_WIDTH < 17);
  localparam logic [16:0] CapLim   = ClampOn ? 17'(64'd1 << ADDR_WIDTH) : '1;
  localparam logic [15:0] AddrMask = (ADDR_WIDTH >= 16) ? 16'hffff
                                   : 16'((64'd1 << ADDR_WIDTH) - 64'd1);

  logic [3:0]  op;
  logic [63:0] sh;
  logic [3:0]  k;
  logic [16:0] pos;

  logic [16:0] eff_cap;
  logic        is_varint;
  logic        last_now;
  logic [7:0]  byte_val;
  logic        full;
  logic [16:0] room;
  logic        skip_over;
  logic [63:0] load_val;

  logic [16:0] pos_n;
  logic [7:0]  res_byte;
  logic [15:0] res_addr;
  logic        res_written;
  logic        res_oos;
  logic [16:0] space_n;

  assign eff_cap = (ClampOn && (capacity > CapLim)) ? CapLim : capacity;

  assign is_varint = (op == wfbs_pkg::OP_VARINT32) || (op == wfbs_pkg::OP_VARINT64) ||
                     (op == wfbs_pkg::OP_INT32);

  always_comb begin
    unique case (op)
      wfbs_pkg::OP_VARINT32, wfbs_pkg::OP_VARINT64, wfbs_pkg::OP_INT32:
        last_now = (sh[63:7] == '0) || (k == wfbs_pkg::VARINT_LAST_STEP);
      wfbs_pkg::OP_FIXED16: last_now = (k == wfbs_pkg::FIX16_LAST);
      wfbs_pkg::OP_FIXED32: last_now = (k == wfbs_pkg::FIX32_LAST);
      wfbs_pkg::OP_FIXED64: last_now = (k == wfbs_pkg::FIX64_LAST);
      default:              last_now = 1'b1;
    endcase
  end

  // varint groups other than the final one carry the continuation bit
  assign byte_val  = (is_varint && !last_now) ? ((sh[7:0] & wfbs_pkg::VAL7) | wfbs_pkg::CONT)
                                              : sh[7:0];
  assign full      = (pos >= eff_cap);
  assign room      = full ? 17'd0 : (eff_cap - pos);
  assign skip_over = (sh[63:17] != '0) || (sh[16:0] > room);

  always_comb begin
    res_addr    = pos[15:0] & AddrMask;
    res_byte    = 8'd0;
    res_written = 1'b0;
    res_oos     = 1'b0;
    pos_n       = pos;
    unique case (op)
      wfbs_pkg::OP_SKIP: begin
        res_oos = skip_over;
        if (skip_over) begin
          pos_n = full ? pos : eff_cap;
        end else begin
          pos_n = pos + sh[16:0];
        end
      end
      wfbs_pkg::OP_RESTART: begin
        res_addr = 16'd0;
        pos_n    = 17'd0;
      end
      default: begin
        if (full) begin
          res_oos = 1'b1;
        end else begin
          res_byte    = byte_val;
          res_written = 1'b1;
          pos_n       = pos + 17'd1;
        end
      end
    endcase
  end

  assign space_n = (pos_n < eff_cap) ? (eff_cap - pos_n) : 17'd0;

  always_comb begin
    unique case (command)
      wfbs_pkg::OP_VARINT32: load_val = {32'd0, value[31:0]};
      wfbs_pkg::OP_INT32:    load_val = {{32{value[31]}}, value[31:0]};
      wfbs_pkg::OP_BOOL:     load_val = {63'd0, |value};
      default:               load_val = value;
    endcase
  end

  assign stat.slot_free = !out_valid || out_ready;
  assign stat.step_last = last_now;

  // operand registers: a load overrides the shift of the item just finishing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= command;
      sh <= load_val;
      k  <= 4'd0;
    end else if (cmd.step) begin
      sh <= is_varint ? (sh >> wfbs_pkg::SHIFT7) : (sh >> wfbs_pkg::SHIFT8);
      k  <= k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 17'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        pos       <= pos_n;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte     <= res_byte;
      byte_address <= res_addr;
      byte_written <= res_written;
      out_of_space <= res_oos;
      space_left   <= space_n;
      last         <= last_now;
    end
  end

endmodule

// File: hdl/wire_field_byte_serializer_top.sv
// Top level: serializes commanded values into addressed buffer bytes.
//
// Input channel (in_valid/in_ready) takes one item: a command and a 64-bit
// value. Output channel (out_valid/out_ready) gives one item per byte, with
// its buffer address, written/dropped flags, space left and a last marker.
// Raw byte, bool, skip and restart give one result; fixed16/32/64 give 2, 4
// or 8; varints give 1 to 10 (a negative int32 always 10). Unknown commands
// are taken and give nothing.
// The item enters the operand registers when accepted; each result is then
// registered in the output register, one result per cycle while out_ready
// does not stall; the next item is accepted together with the final result
// of the current one.
// A stall on out_ready holds the output register and the sequencer; the
// input channel stays closed until the item's final result enters the
// output register.
// Reset clears the write position, empties the output register and sets
// capacity to 65536. Capacity is written over the APB port at byte
// address 0 by the user only while the block is idle; nothing enforces it.
module wire_field_byte_serializer_top #(
  parameter int unsigned ADDR_WIDTH = wfbs_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [15:0] byte_address,
  output logic        byte_written,
  output logic        out_of_space,
  output logic [16:0] space_left,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0]        capacity;
  logic               cfg_we;
  wfbs_pkg::dp_cmd_t  cmd;
  wfbs_pkg::dp_stat_t stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == wfbs_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == wfbs_pkg::REG_CAPACITY) ? {15'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= wfbs_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= pwdata[16:0];
    end
  end

  wfbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wfbs_dp #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (command),
    .value        (value),
    .capacity     (capacity),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .byte_address (byte_address),
    .byte_written (byte_written),
    .out_of_space (out_of_space),
    .space_left   (space_left),
    .last         (last)
  );

endmodule

// File: hdl/wfbs_checker.sv
// Port-level checks for the serializer top, bound in below
`include "wire_field_byte_serializer_top_defines.svh"

module wfbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_written,
  input logic        out_of_space,
  input logic        last
);

  `WFBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last), "result item changed while stalled")
  `WFBS_NEVER(a_written_xor_drop, out_valid && byte_written && out_of_space, "byte both stored and dropped")
  `WFBS_NEVER(a_unwritten_zero, out_valid && !byte_written && (out_byte != 8'd0), "unwritten byte not zero")
  // an item in mid-flight with a stalled result keeps the input closed
  `WFBS_NEVER(a_busy_closed, out_valid && !last && !out_ready && in_ready, "input open mid item")

endmodule

bind wire_field_byte_serializer_top wfbs_checker u_wfbs_checker (.*);

// File: test/wfbs_byte_checker.sv
`timescale 1ns / 1ps
// Checker: follows both channels and the config port, predicts each byte and compares it
module wfbs_byte_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  command,
  input  logic [63:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic [15:0] byte_address,
  input  logic        byte_written,
  input  logic        out_of_space,
  input  logic [16:0] space_left,
  input  logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import wfbs_pkg::*;

  localparam logic [16:0] ADDR_SPAN = 17'd1 << ADDR_WIDTH_DEF;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] addr;
    logic        written;
    logic        dropped;
    logic [16:0] room;
    logic        fin;
  } wire_byte_t;

  wire_byte_t  expected_bytes[$];
  logic [16:0] cap_reg = CAP_RESET;
  logic [16:0] wr_pos = '0;

  function automatic logic [16:0] usable_cap();
    return (cap_reg > ADDR_SPAN) ? ADDR_SPAN : cap_reg;
  endfunction

  function automatic logic [16:0] room_now();
    return (wr_pos < usable_cap()) ? usable_cap() - wr_pos : 17'd0;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic fin);
    wire_byte_t e;
    e.addr = wr_pos[15:0];
    if (wr_pos >= usable_cap()) begin
      // buffer full: byte is reported but dropped
      e.data = 8'd0;
      e.written = 1'b0;
      e.dropped = 1'b1;
    end else begin
      wr_pos = wr_pos + 17'd1;
      e.data = b;
      e.written = 1'b1;
      e.dropped = 1'b0;
    end
    e.room = room_now();
    e.fin = fin;
    expected_bytes.push_back(e);
  endtask

  task automatic push_varint(input logic [63:0] v);
    int k = 0;
    while ((v & ~64'h7f) != 64'd0 && k < 9) begin
      push_byte(CONT | {1'b0, v[6:0]}, 1'b0);
      v = v >> SHIFT7;
      k++;
    end
    push_byte(v[7:0], 1'b1);
  endtask

  task automatic push_fixed(input logic [63:0] v, input logic [3:0] last_idx);
    for (int k = 0; k <= last_idx; k++)
      push_byte(v[8*k +: 8], k == last_idx);
  endtask

  task automatic encode_item(input logic [3:0] cmd, input logic [63:0] v);
    wire_byte_t  e;
    logic [16:0] cap;
    logic [16:0] room;
    case (cmd)
      OP_RAW:      push_byte(v[7:0], 1'b1);
      OP_BOOL:     push_byte({7'd0, v != 64'd0}, 1'b1);
      OP_VARINT32: push_varint({32'd0, v[31:0]});
      OP_VARINT64: push_varint(v);
      OP_INT32:    push_varint({{32{v[31]}}, v[31:0]});
      OP_FIXED16:  push_fixed(v, FIX16_LAST);
      OP_FIXED32:  push_fixed(v, FIX32_LAST);
      OP_FIXED64:  push_fixed(v, FIX64_LAST);
      OP_SKIP: begin
        e.addr = wr_pos[15:0];
        cap = usable_cap();
        room = room_now();
        e.dropped = 1'b0;
        if (v > {47'd0, room}) begin
          // saturate at capacity, never move a position already past it
          e.dropped = 1'b1;
          if (wr_pos < cap) wr_pos = cap;
        end else begin
          wr_pos = wr_pos + v[16:0];
        end
        e.data = 8'd0;
        e.written = 1'b0;
        e.room = room_now();
        e.fin = 1'b1;
        expected_bytes.push_back(e);
      end
      OP_RESTART: begin
        wr_pos = '0;
        e.data = 8'd0;
        e.addr = 16'd0;
        e.written = 1'b0;
        e.dropped = 1'b0;
        e.room = room_now();
        e.fin = 1'b1;
        expected_bytes.push_back(e);
      end
      default: ;  // unknown command: no bytes, no state change
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    wire_byte_t got;
    wire_byte_t want;
    if (rst) begin
      cap_reg = CAP_RESET;
      wr_pos = '0;
      expected_bytes.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_CAPACITY) begin
        if (pwrite) cap_reg = pwdata[16:0];
        else check_field("prdata", {15'd0, cap_reg}, prdata);
      end
      if (in_valid && in_ready) encode_item(command, value);
      if (out_valid && out_ready) begin
        got = {out_byte, byte_address, byte_written, out_of_space, space_left, last};
        if (expected_bytes.size() == 0) begin
          $error("out_byte: item 0x%0h arrived with nothing expected", out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.data, got.data);
          check_field("byte_address", want.addr, got.addr);
          check_field("byte_written", want.written, got.written);
          check_field("out_of_space", want.dropped, got.dropped);
          check_field("space_left", want.room, got.room);
          check_field("last", want.fin, got.fin);
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// File: test/tb_wire_field_byte_serializer_top.sv
`timescale 1ns / 1ps
// Testbench top: drives items, capacity writes and back-pressure, and gives the verdict
module tb_wire_field_byte_serializer_top;
  import wfbs_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'hf;
  localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
  localparam logic [2:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  command = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [15:0] byte_address;
  logic        byte_written;
  logic        out_of_space;
  logic [16:0] space_left;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  bit steady = 1'b0;

  always #6 clk = ~clk;

  wire_field_byte_serializer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_address(byte_address), .byte_written(byte_written),
    .out_of_space(out_of_space), .space_left(space_left), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wfbs_byte_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_address(byte_address), .byte_written(byte_written),
    .out_of_space(out_of_space), .space_left(space_left), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= steady || ($urandom_range(99) >= 19);
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic [3:0] cmd, input logic [63:0] val);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender pauses until every expected item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // unknown commands may still be in flight
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input logic [31:0] data);
    drain();
    apb_access(1'b1, CAP_ADDR, data);
    apb_access(1'b0, CAP_ADDR, '0);
  endtask

  function automatic logic [63:0] rand_value(input logic [3:0] cmd);
    logic [63:0] full;
    full = {$urandom, $urandom};
    if (cmd == OP_SKIP)
      return ($urandom_range(9) == 0) ? full : 64'($urandom_range(40));
    case ($urandom_range(3))
      0: return full;
      1: return full >> $urandom_range(63);
      2: return 64'($urandom_range(255));
      default: return {full[63:32], 1'b1, full[30:0]};  // negative low word
    endcase
  endfunction

  task automatic random_phase(input int n);
    int sent = 0;
    int pick;
    logic [3:0] cmd;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 4) cmd = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      else if (pick < 12) cmd = OP_RESTART;
      else if (pick < 20) cmd = OP_SKIP;
      else cmd = 4'($urandom_range(OP_FIXED64, OP_RAW));
      send_item(cmd, rand_value(cmd));
      if (cmd <= OP_RESTART) sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // every encoding and its edge values, default capacity
    send_item(OP_RAW, 64'h0);
    send_item(OP_RAW, 64'hffff_ffff_ffff_ff5a);
    send_item(OP_BOOL, 64'h0);
    send_item(OP_BOOL, 64'h8000_0000_0000_0000);
    send_item(OP_VARINT32, 64'h7f);
    send_item(OP_VARINT32, 64'h80);
    send_item(OP_VARINT32, 64'hdead_beef_ffff_ffff);
    send_item(OP_VARINT64, 64'hffff_ffff_ffff_ffff);
    send_item(OP_VARINT64, 64'h8000_0000_0000_0000);
    send_item(OP_INT32, 64'h0000_0000_ffff_ffff);
    send_item(OP_INT32, 64'h1234_5678_7fff_ffff);
    send_item(OP_FIXED16, 64'hffff_ffff_ffff_a55a);
    send_item(OP_FIXED32, 64'h0123_4567);
    send_item(OP_FIXED64, 64'hfedc_ba98_7654_3210);
    send_item(CMD_UNUSED_LO, 64'h55);
    send_item(OP_SKIP, 64'd0);
    send_item(OP_SKIP, 64'hffff_ffff_ffff_ffff);
    send_item(OP_RAW, 64'h11);
    send_item(CMD_UNUSED_HI, 64'hffff_ffff_ffff_ffff);
    send_item(OP_RESTART, 64'hffff_ffff_ffff_ffff);

    // zero capacity: every byte dropped
    set_capacity(32'd0);
    send_item(OP_VARINT64, 64'hffff_ffff_ffff_ffff);
    send_item(OP_SKIP, 64'd0);
    send_item(OP_SKIP, 64'd1);
    // upper data bits ignored, capacity becomes 3; spare register write ignored
    set_capacity(32'hfffe_0003);
    apb_access(1'b1, SPARE_ADDR, 32'hffff_ffff);
    send_item(OP_FIXED32, 64'haabb_ccdd);
    send_item(OP_RESTART, 64'd0);
    send_item(OP_FIXED16, 64'h1234);
    // capacity lowered below the position
    set_capacity({15'd0, CAP_RESET});
    send_item(OP_SKIP, 64'd1000);
    set_capacity(32'd40);
    send_item(OP_VARINT32, 64'h3fff);
    send_item(OP_SKIP, 64'd5);
    send_item(OP_RESTART, 64'd0);

    set_capacity(32'h0001_0000);
    hold_req = 1'b1;
    random_phase(60);
    set_capacity(32'h0001_ffff);
    steady = 1'b1;
    random_phase(50);
    steady = 1'b0;
    set_capacity(32'd300);
    random_phase(50);
    set_capacity(32'd1);
    random_phase(30);
    set_capacity(32'h0000_ffff);
    random_phase(40);
    set_capacity($urandom);
    random_phase(40);
    set_capacity(32'd64);
    random_phase(50);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/wfbs_pkg.sv
hdl/wfbs_ctrl.sv
hdl/wfbs_dp.sv
hdl/wire_field_byte_serializer_top.sv
hdl/wfbs_checker.sv
test/wfbs_byte_checker.sv
test/tb_wire_field_byte_serializer_top.sv
